// ===== rtl/core/mse_pkg.sv =====
// Shared types and constants for the merge sort engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package mse_pkg;

   localparam int MSE_MAX_ITEMS  = 64;
   localparam int MSE_DATA_WIDTH = 32;

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_SORT = 3'b010,
      ST_EMIT = 3'b100
   } mse_state_type;

   // Bank control from the sequencer to the two memories.
   typedef struct packed {
      logic we_store;   // write element store
      logic we_merge;   // write merge buffer
      logic src_sel;    // 1: current read data comes from merge buffer
   } mse_bank_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/core/mse_ram.sv =====
// One write, two read synchronous memory; read data is registered.
// A read of the address being written returns the new word. Uses mse_pkg.
`default_nettype none

module mse_ram #(
   parameter int DEPTH = mse_pkg::MSE_MAX_ITEMS,
   parameter int WIDTH = mse_pkg::MSE_DATA_WIDTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr_a,
   input  wire logic [AW-1:0]    raddr_b,
   output logic      [WIDTH-1:0] rdata_a,
   output logic      [WIDTH-1:0] rdata_b
);
   import mse_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
      rdata_b <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
   end

endmodule

`default_nettype wire

// ===== rtl/core/mse_seq.sv =====
// Sequencer of the merge sort engine: load, bottom-up merge passes, emit.
// Drives both memory banks and holds the result register. Uses mse_pkg.
`default_nettype none

module mse_seq #(
   parameter int MAX_ITEMS  = mse_pkg::MSE_MAX_ITEMS,
   parameter int DATA_WIDTH = mse_pkg::MSE_DATA_WIDTH,
   parameter int AW         = $clog2(MAX_ITEMS)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [DATA_WIDTH-1:0] req_value,
   input  wire logic                         req_is_final,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed      [DATA_WIDTH-1:0] rsp_sorted_value,
   output logic                              rsp_end_of_set,
   output logic                              rsp_dropped,
   output mse_pkg::mse_bank_ctrl_type        bank_ctrl,
   output logic             [AW-1:0]         waddr,
   output logic             [DATA_WIDTH-1:0] wdata,
   output logic             [AW-1:0]         raddr_a,
   output logic             [AW-1:0]         raddr_b,
   input  wire logic        [DATA_WIDTH-1:0] rd_a,
   input  wire logic        [DATA_WIDTH-1:0] rd_b
);
   import mse_pkg::*;

   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int PW = CW + 1;
   localparam logic [CW-1:0] MAXC = CW'(MAX_ITEMS);

   mse_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic          src_sel_ff, src_sel_in;
   // l/r: heads of left and right run (also the read addresses in flight)
   logic [PW-1:0] l_ff, l_in, r_ff, r_in, k_ff, k_in;
   logic [PW-1:0] mid_ff, mid_in, hi_ff, hi_in, wid_ff, wid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] out_val_ff, out_val_in;
   logic          end_ff, end_in, drop_ff, drop_in;

   logic [PW-1:0] n_x, wid2, mid_nx, hi_nx, sum_a, sum_b;
   logic [CW-1:0] n_new;
   logic          take_left, load_out;

   assign n_x = {1'b0, cnt_ff};
   assign take_left = (l_ff < mid_ff) &&
                      ((r_ff >= hi_ff) || ($signed(rd_a) < $signed(rd_b)));
   assign load_out = !rsp_valid_ff || rsp_ready;
   assign wid2 = wid_ff << 1;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      src_sel_in   = src_sel_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      k_in         = k_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      wid_in       = wid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_val_in   = out_val_ff;
      end_in       = end_ff;
      drop_in      = drop_ff;
      bank_ctrl    = '{we_store: 1'b0, we_merge: 1'b0, src_sel: src_sel_ff};
      waddr        = k_ff[AW-1:0];
      wdata        = take_left ? rd_a : rd_b;
      req_ready    = 1'b0;
      n_new        = cnt_ff;
      mid_nx       = '0;
      hi_nx        = '0;
      sum_a        = '0;
      sum_b        = '0;

      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            waddr     = cnt_ff[AW-1:0];
            wdata     = req_value;
            if (req_valid) begin
               if (cnt_ff < MAXC) begin
                  bank_ctrl.we_store = 1'b1;
                  n_new              = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               cnt_in = n_new;
               if (req_is_final) begin
                  src_sel_in = 1'b0;
                  wid_in     = PW'(1);
                  l_in       = '0;
                  r_in       = PW'(1);
                  k_in       = '0;
                  mid_in     = PW'(1);
                  hi_in      = (n_new > CW'(2)) ? PW'(2) : {1'b0, n_new};
                  state_in   = (n_new == CW'(1)) ? ST_EMIT : ST_SORT;
               end
            end
         end

         ST_SORT: begin
            bank_ctrl.we_merge = !src_sel_ff;
            bank_ctrl.we_store = src_sel_ff;
            if (take_left) begin
               l_in = l_ff + 1'b1;
            end else begin
               r_in = r_ff + 1'b1;
            end
            k_in = k_ff + 1'b1;
            if (k_in == hi_ff) begin
               if (hi_ff == n_x) begin
                  // pass done: swap banks; then either emit or double the run width
                  src_sel_in = !src_sel_ff;
                  l_in       = '0;
                  if (wid2 >= n_x) begin
                     state_in = ST_EMIT;
                  end else begin
                     sum_b  = wid2 + wid2;
                     hi_nx  = (sum_b > n_x) ? n_x : sum_b;
                     wid_in = wid2;
                     k_in   = '0;
                     mid_in = wid2;
                     r_in   = wid2;
                     hi_in  = hi_nx;
                  end
               end else begin
                  // next pair of runs starts where this one ended
                  sum_a  = hi_ff + wid_ff;
                  mid_nx = (sum_a > n_x) ? n_x : sum_a;
                  sum_b  = mid_nx + wid_ff;
                  hi_nx  = (sum_b > n_x) ? n_x : sum_b;
                  l_in   = hi_ff;
                  r_in   = mid_nx;
                  mid_in = mid_nx;
                  hi_in  = hi_nx;
               end
            end
         end

         ST_EMIT: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               out_val_in   = rd_a;
               end_in       = ((l_ff + 1'b1) == n_x);
               drop_in      = ovf_ff;
               l_in         = l_ff + 1'b1;
               if (end_in) begin
                  state_in = ST_LOAD;
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
                  l_in     = '0;
                  r_in     = PW'(1);
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign raddr_a = l_in[AW-1:0];
   assign raddr_b = r_in[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         src_sel_ff   <= 1'b0;
         l_ff         <= '0;
         r_ff         <= PW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         src_sel_ff   <= src_sel_in;
         l_ff         <= l_in;
         r_ff         <= r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      mid_ff     <= mid_in;
      hi_ff      <= hi_in;
      wid_ff     <= wid_in;
      out_val_ff <= out_val_in;
      end_ff     <= end_in;
      drop_ff    <= drop_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = out_val_ff;
   assign rsp_end_of_set   = end_ff;
   assign rsp_dropped      = drop_ff;

   a_sort_k_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SORT) |-> (k_ff < n_x))
      else $error("merge write index beyond set size");

   a_sort_ptr_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SORT) |-> ((k_ff + mid_ff) == (l_ff + r_ff)))
      else $error("merge pointers out of step with write index");

   a_emit_start: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_EMIT) |-> (l_ff == '0))
      else $error("emit does not start at element zero");

   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAXC)
      else $error("element count above capacity");

   a_end_returns: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && load_out && end_in) |=>
      ((state_ff == ST_LOAD) && (cnt_ff == '0) && !ovf_ff))
      else $error("last word of set did not return to load");

endmodule

`default_nettype wire

// ===== rtl/core/merge_sort_engine_core.sv =====
// Merge sort engine top level: element store, merge buffer and sequencer.
// Depends on mse_pkg, mse_ram and mse_seq.
//
// Words are collected one per cycle into the element store; the word flagged
// final closes the set. Words beyond MAX_ITEMS are discarded and every
// result of that set then carries dropped. The set of n words is sorted by a
// bottom-up merge that ping-pongs between the element store and the merge
// buffer, writing one word per cycle in each of ceil(log2 n) passes.
// Sorted words are then emitted at one per cycle from the result register
// while the consumer keeps up; the last one carries end_of_set. Ties take
// the word of the right run first. The next set can be loaded while the last
// result waits.
`default_nettype none

module merge_sort_engine_core #(
   parameter int MAX_ITEMS  = mse_pkg::MSE_MAX_ITEMS,
   parameter int DATA_WIDTH = mse_pkg::MSE_DATA_WIDTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [DATA_WIDTH-1:0] req_value,
   input  wire logic                         req_is_final,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed      [DATA_WIDTH-1:0] rsp_sorted_value,
   output logic                              rsp_end_of_set,
   output logic                              rsp_dropped
);
   import mse_pkg::*;

   localparam int AW = $clog2(MAX_ITEMS);

   mse_bank_ctrl_type     bank_ctrl;
   logic [AW-1:0]         waddr, raddr_a, raddr_b;
   logic [DATA_WIDTH-1:0] wdata;
   logic [DATA_WIDTH-1:0] st_rd_a, st_rd_b, mg_rd_a, mg_rd_b, rd_a, rd_b;

   mse_ram #(.DEPTH(MAX_ITEMS), .WIDTH(DATA_WIDTH), .AW(AW)) u_store (
      .clock   (clock),
      .we      (bank_ctrl.we_store),
      .waddr   (waddr),
      .wdata   (wdata),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (st_rd_a),
      .rdata_b (st_rd_b)
   );

   mse_ram #(.DEPTH(MAX_ITEMS), .WIDTH(DATA_WIDTH), .AW(AW)) u_merge (
      .clock   (clock),
      .we      (bank_ctrl.we_merge),
      .waddr   (waddr),
      .wdata   (wdata),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (mg_rd_a),
      .rdata_b (mg_rd_b)
   );

   // source bank of the current pass
   assign rd_a = bank_ctrl.src_sel ? mg_rd_a : st_rd_a;
   assign rd_b = bank_ctrl.src_sel ? mg_rd_b : st_rd_b;

   mse_seq #(.MAX_ITEMS(MAX_ITEMS), .DATA_WIDTH(DATA_WIDTH), .AW(AW)) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_is_final     (req_is_final),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_end_of_set   (rsp_end_of_set),
      .rsp_dropped      (rsp_dropped),
      .bank_ctrl        (bank_ctrl),
      .waddr            (waddr),
      .wdata            (wdata),
      .raddr_a          (raddr_a),
      .raddr_b          (raddr_b),
      .rd_a             (rd_a),
      .rd_b             (rd_b)
   );

endmodule

`default_nettype wire
